// File: rtl/core/repeating_timer_scheduler_assert.svh
// Assertion macros for the timer scheduler checker.
`ifndef REPEATING_TIMER_SCHEDULER_ASSERT_SVH
`define REPEATING_TIMER_SCHEDULER_ASSERT_SVH

// Checked at every clock edge outside of reset.
`define RTS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define RTS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/rts_pkg.sv
// Shared types and constants of the repeating timer scheduler.
package rts_pkg;

    localparam int ID_W  = 3;
    localparam int DL_W  = 48;
    localparam int PER_W = 32;
    localparam int CNT_W = 16;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    localparam int S_ID_LO  = 0;
    localparam int S_DL_LO  = S_ID_LO + ID_W;
    localparam int S_PER_LO = S_DL_LO + DL_W;
    localparam int S_CNT_LO = S_PER_LO + PER_W;
    localparam int S_FEV_LO = S_CNT_LO + CNT_W;

    localparam int M_ID_LO  = 0;
    localparam int M_CNT_LO = M_ID_LO + ID_W;

    typedef enum logic [S_TUSER_W-1:0] {
        REQ_TICK     = 2'd0,
        REQ_ONESHOT  = 2'd1,
        REQ_INTERVAL = 2'd2,
        REQ_STOP     = 2'd3
    } req_t;

    typedef struct packed {
        logic accept;
        logic run_start;
        logic run_scan;
        logic run_flush;
    } cmd_t;

    typedef struct packed {
        logic stall;
        logic scan_last;
    } sts_t;

endpackage

// File: rtl/core/rts_ctrl.sv
// Control state machine of the repeating timer scheduler.
module rts_ctrl import rts_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic is_tick,
    input  sts_t sts,
    output logic s_tready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_tready_reg;
    logic   s_tready_next;

    always_comb begin
        cmd.accept    = s_tvalid && s_tready_reg;
        cmd.run_start = (state_reg == ST_START);
        cmd.run_scan  = (state_reg == ST_SCAN);
        cmd.run_flush = (state_reg == ST_FLUSH);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = is_tick ? ST_SCAN : ST_START;
                end
            end
            ST_START: begin
                if (!sts.stall) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (!sts.stall && sts.scan_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!sts.stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        s_tready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            s_tready_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
        end
    end

    assign s_tready = s_tready_reg;

endmodule

// File: rtl/core/rts_datapath.sv
// Datapath of the repeating timer scheduler: slot memory, tick counter and result register.
module rts_datapath import rts_pkg::*; #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW    = (TIME_BITS > DL_W) ? TIME_BITS : DL_W;
    localparam int SW    = ((TIME_BITS > PER_W) ? TIME_BITS : PER_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic [TIME_BITS-1:0] dl_mem   [NUM_TIMERS];
    logic [PER_W-1:0]     per_mem  [NUM_TIMERS];
    logic [CNT_W-1:0]     left_mem [NUM_TIMERS];
    logic                 fev_mem  [NUM_TIMERS];

    logic [TIME_BITS-1:0] dl_rd_reg;
    logic [PER_W-1:0]     per_rd_reg;
    logic [CNT_W-1:0]     left_rd_reg;
    logic                 fev_rd_reg;

    logic [TIME_BITS-1:0]  now_reg;
    logic [TIME_BITS-1:0]  now_next;
    logic [NUM_TIMERS-1:0] active_reg;
    logic [NUM_TIMERS-1:0] active_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [IDX_W-1:0]      pend_id_reg;
    logic [IDX_W-1:0]      pend_id_next;

    req_t                  req_type_reg;
    logic [ID_W-1:0]       req_id_reg;
    logic [DL_W-1:0]       req_dl_reg;
    logic [PER_W-1:0]      req_per_reg;
    logic [CNT_W-1:0]      req_cnt_reg;
    logic                  req_fev_reg;

    logic                  out_valid_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic [CNT_W-1:0]      out_cnt_reg;
    logic                  out_last_reg;
    logic                  out_free;

    logic [IDX_W-1:0]      req_idx;
    logic                  id_ok;
    logic                  os_due;
    logic [TIME_BITS-1:0]  os_dl;
    logic                  iv_ignore;
    logic                  iv_zero;
    logic                  start_fires;

    logic [TIME_BITS-1:0]  add_a;
    logic [PER_W-1:0]      add_b;
    logic [SW-1:0]         sum;
    logic [TIME_BITS-1:0]  sat_sum;

    logic                  due;
    logic [CNT_W-1:0]      left_dec;
    logic                  keep;
    logic                  scan_last;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [TIME_BITS-1:0]  wr_dl;
    logic [PER_W-1:0]      wr_per;
    logic [CNT_W-1:0]      wr_left;
    logic                  wr_fev;

    logic                  emit;
    logic [IDX_W-1:0]      emit_id;
    logic [CNT_W-1:0]      emit_cnt;
    logic                  emit_last;
    logic                  stall;

    assign out_free = !out_valid_reg || m_tready;

    assign req_idx   = IDX_W'(req_id_reg);
    assign id_ok     = 32'(req_id_reg) < 32'(NUM_TIMERS);
    assign os_due    = CW'(req_dl_reg) <= CW'(now_reg);
    assign os_dl     = (CW'(req_dl_reg) > CW'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(req_dl_reg);
    assign iv_ignore = !req_fev_reg && (req_cnt_reg == '0);
    assign iv_zero   = (req_per_reg == '0);
    assign start_fires = id_ok && (((req_type_reg == REQ_ONESHOT) && os_due) ||
                                   ((req_type_reg == REQ_INTERVAL) && !iv_ignore && iv_zero));

    assign add_a   = cmd.run_scan ? dl_rd_reg : now_reg;
    assign add_b   = cmd.run_scan ? per_rd_reg : req_per_reg;
    assign sum     = SW'(add_a) + SW'(add_b);
    assign sat_sum = (sum > SW'(TIME_MAX)) ? TIME_MAX : sum[TIME_BITS-1:0];

    assign due       = active_reg[idx_reg] && (dl_rd_reg <= now_reg);
    assign left_dec  = fev_rd_reg ? left_rd_reg : (left_rd_reg - CNT_W'(1));
    assign keep      = fev_rd_reg || (left_dec != '0);
    assign scan_last = (32'(idx_reg) == 32'(NUM_TIMERS - 1));

    assign now_next = (now_reg == TIME_MAX) ? now_reg : (now_reg + TIME_BITS'(1));

    always_comb begin
        wr_en           = 1'b0;
        wr_addr         = req_idx;
        wr_dl           = dl_rd_reg;
        wr_per          = per_rd_reg;
        wr_left         = left_rd_reg;
        wr_fev          = fev_rd_reg;
        active_next     = active_reg;
        emit            = 1'b0;
        emit_id         = req_idx;
        emit_cnt        = CNT_W'(1);
        emit_last       = 1'b1;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        idx_next        = idx_reg;
        stall           = 1'b0;

        if (cmd.run_start) begin
            stall = start_fires && !out_free;
            if (!stall && id_ok) begin
                case (req_type_reg)
                    REQ_STOP: begin
                        active_next[req_idx] = 1'b0;
                    end
                    REQ_ONESHOT: begin
                        wr_en                = 1'b1;
                        wr_per               = '0;
                        wr_left              = CNT_W'(1);
                        wr_fev               = 1'b0;
                        wr_dl                = os_due ? '0 : os_dl;
                        active_next[req_idx] = !os_due;
                        emit                 = os_due;
                    end
                    REQ_INTERVAL: begin
                        if (!iv_ignore) begin
                            wr_en  = 1'b1;
                            wr_per = req_per_reg;
                            wr_fev = req_fev_reg;
                            if (iv_zero) begin
                                wr_dl                = '0;
                                wr_left              = '0;
                                active_next[req_idx] = 1'b0;
                                emit                 = 1'b1;
                                emit_cnt             = req_fev_reg ? CNT_W'(1) : req_cnt_reg;
                            end else begin
                                wr_dl                = sat_sum;
                                wr_left              = req_cnt_reg;
                                active_next[req_idx] = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (cmd.run_scan) begin
            stall = due && pend_valid_reg && !out_free;
            if (!stall) begin
                idx_next = scan_last ? '0 : (idx_reg + IDX_W'(1));
                if (due) begin
                    wr_en                = 1'b1;
                    wr_addr              = idx_reg;
                    wr_left              = left_dec;
                    wr_dl                = keep ? sat_sum : dl_rd_reg;
                    active_next[idx_reg] = keep;
                    if (pend_valid_reg) begin
                        emit      = 1'b1;
                        emit_id   = pend_id_reg;
                        emit_last = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = idx_reg;
                end
            end
        end

        if (cmd.run_flush) begin
            stall = pend_valid_reg && !out_free;
            if (pend_valid_reg && !stall) begin
                emit            = 1'b1;
                emit_id         = pend_id_reg;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dl_mem[wr_addr]   <= wr_dl;
            per_mem[wr_addr]  <= wr_per;
            left_mem[wr_addr] <= wr_left;
            fev_mem[wr_addr]  <= wr_fev;
        end
        dl_rd_reg   <= dl_mem[idx_next];
        per_rd_reg  <= per_mem[idx_next];
        left_rd_reg <= left_mem[idx_next];
        fev_rd_reg  <= fev_mem[idx_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_type_reg <= req_t'(s_tuser);
            req_id_reg   <= s_tdata[S_ID_LO +: ID_W];
            req_dl_reg   <= s_tdata[S_DL_LO +: DL_W];
            req_per_reg  <= s_tdata[S_PER_LO +: PER_W];
            req_cnt_reg  <= s_tdata[S_CNT_LO +: CNT_W];
            req_fev_reg  <= s_tdata[S_FEV_LO];
        end
        pend_id_reg <= pend_id_next;
        if (emit) begin
            out_id_reg   <= ID_W'(emit_id);
            out_cnt_reg  <= emit_cnt;
            out_last_reg <= emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg        <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.accept && (req_t'(s_tuser) == REQ_TICK)) begin
                now_reg <= now_next;
            end
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.stall     = stall;
    assign sts.scan_last = scan_last;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - ID_W - CNT_W){1'b0}}, out_cnt_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/core/repeating_timer_scheduler.sv
// Top level of the repeating timer scheduler.
// A start or stop transaction passes through the start state before the next is taken.
// A tick scans every slot, one slot memory read and update per cycle unless the output stalls, then a flush.
// A stalled output holds the scheduler in its current state.
// One request is in work at a time; s_tready is high only when the block is idle.
// Synchronous reset clears the tick counter, all active marks and the output valid flag.
module repeating_timer_scheduler import rts_pkg::*; #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // timer_id, deadline_at, period, repeat_count, repeat_forever, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // fired_id, fire_count, zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    cmd_t cmd;
    sts_t sts;
    logic is_tick;

    assign is_tick = (req_t'(s_tuser) == REQ_TICK);

    rts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .is_tick  (is_tick),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rts_datapath #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: rtl/core/rts_checker.sv
// Port-level checker of the repeating timer scheduler and its bind.
`include "repeating_timer_scheduler_assert.svh"

module rts_checker import rts_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    `RTS_ASSERT_ALWAYS(a_no_result_after_reset, !aresetn |=> !m_tvalid, "result valid after reset")
    `RTS_ASSERT(a_one_request_at_a_time, (s_tvalid && s_tready) |=> !s_tready, "ready right after a transaction")
    `RTS_ASSERT(a_count_nonzero, m_tvalid |-> (m_tdata[M_CNT_LO +: CNT_W] != '0), "zero fire count")
    `RTS_ASSERT(a_result_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

endmodule

bind repeating_timer_scheduler rts_checker u_rts_checker (.*);
